@@ hw/rtl/ps2_mouse_packet_tracker_top_assert.svh @@
// Assertion macros shared by the checkers of the packet tracker.
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_ASSERT_SVH

// Condition a implies condition b in the same cycle.
`define PMPT_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pmpt assertion failed");

// Condition a implies condition b in the next cycle.
`define PMPT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("pmpt assertion failed");

`endif

@@ hw/rtl/pmpt_pkg.sv @@
`default_nettype none
package pmpt_pkg;

	localparam int POS_BITS = 12;
	localparam int SUM_BITS = POS_BITS + 2;

	localparam logic [7:0] ST_OUT_FULL = 8'h01;
	localparam logic [7:0] ST_AUX      = 8'h20;
	localparam logic [7:0] SYNC_BIT    = 8'h08;
	localparam logic [7:0] OVF_BITS    = 8'hC0;
	localparam logic [7:0] BTN_BITS    = 8'h07;

	localparam logic [POS_BITS-1:0] MAX_X_RST  = POS_BITS'(79);
	localparam logic [POS_BITS-1:0] MAX_Y_RST  = POS_BITS'(24);
	localparam logic [POS_BITS-1:0] CURS_X_RST = POS_BITS'(40);
	localparam logic [POS_BITS-1:0] CURS_Y_RST = POS_BITS'(12);

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MAX_X   = 2'd0;
	localparam cfg_idx_t REG_MAX_Y   = 2'd1;
	localparam cfg_idx_t REG_START_X = 2'd2;
	localparam cfg_idx_t REG_START_Y = 2'd3;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [POS_BITS-1:0] pos_x;
		logic [POS_BITS-1:0] pos_y;
		logic [2:0]          button_bits;
	} out_item_t;

	typedef struct packed {
		logic                valid;
		cfg_idx_t            index;
		logic [POS_BITS-1:0] data;
	} cfg_req_t;

	// Handshake between the input register and the result register.
	typedef struct packed {
		logic fire;
	} flow_t;

endpackage
`default_nettype wire

@@ hw/rtl/pmpt_in_stage.sv @@
`default_nettype none
module pmpt_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire pmpt_pkg::in_item_t item,
	input  wire logic             advance,
	output pmpt_pkg::flow_t       flow,
	output pmpt_pkg::in_item_t    item_s1
);
	import pmpt_pkg::*;

	logic valid_s1;

	assign item_stall   = valid_s1 & ~advance;
	assign flow.fire    = valid_s1 & advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/pmpt_core.sv @@
`default_nettype none
module pmpt_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pmpt_pkg::flow_t    flow,
	input  wire pmpt_pkg::in_item_t item_s1,
	input  wire pmpt_pkg::cfg_req_t cfg,
	output logic                    res_valid,
	output pmpt_pkg::out_item_t     res
);
	import pmpt_pkg::*;

	localparam logic [1:0] BP_HEAD = 2'd0;
	localparam logic [1:0] BP_DX   = 2'd1;
	localparam logic [1:0] BP_DY   = 2'd2;

	logic [1:0]          byte_pos_q, byte_pos_d;
	logic [7:0]          head_q, head_d;
	logic [7:0]          dx_q, dx_d;
	logic [POS_BITS-1:0] cur_x_q, cur_x_d;
	logic [POS_BITS-1:0] cur_y_q, cur_y_d;
	logic [2:0]          btn_q, btn_d;
	logic [POS_BITS-1:0] max_x_q, max_x_d;
	logic [POS_BITS-1:0] max_y_q, max_y_d;

	logic signed [SUM_BITS-1:0] sum_x;
	logic signed [SUM_BITS-1:0] sum_y;
	logic                       take;

	function automatic logic [POS_BITS-1:0] clamp_pos(
		input logic signed [SUM_BITS-1:0] v,
		input logic [POS_BITS-1:0] hi
	);
		logic signed [SUM_BITS-1:0] hi_s;
		hi_s = $signed({2'b00, hi});
		if (v < 0) begin
			return '0;
		end else if (v > hi_s) begin
			return hi;
		end
		return v[POS_BITS-1:0];
	endfunction

	assign sum_x = $signed({2'b00, cur_x_q})
		+ $signed({{(SUM_BITS-8){dx_q[7]}}, dx_q});
	assign sum_y = $signed({2'b00, cur_y_q})
		- $signed({{(SUM_BITS-8){item_s1.data_byte[7]}}, item_s1.data_byte});

	// Only aux bytes with output full take part in the packet.
	assign take = flow.fire
		&& ((item_s1.status_byte & ST_OUT_FULL) != 8'h00)
		&& ((item_s1.status_byte & ST_AUX) != 8'h00);

	always_comb begin
		byte_pos_d = byte_pos_q;
		head_d     = head_q;
		dx_d       = dx_q;
		cur_x_d    = cur_x_q;
		cur_y_d    = cur_y_q;
		btn_d      = btn_q;
		max_x_d    = max_x_q;
		max_y_d    = max_y_q;
		res_valid  = 1'b0;

		if (take) begin
			unique case (byte_pos_q)
				BP_HEAD: begin
					// Drop a head byte without the sync bit to regain alignment.
					if ((item_s1.data_byte & SYNC_BIT) != 8'h00) begin
						head_d     = item_s1.data_byte;
						byte_pos_d = BP_DX;
					end
				end
				BP_DX: begin
					dx_d       = item_s1.data_byte;
					byte_pos_d = BP_DY;
				end
				default: begin
					byte_pos_d = BP_HEAD;
					if ((head_q & OVF_BITS) == 8'h00) begin
						cur_x_d   = clamp_pos(sum_x, max_x_q);
						cur_y_d   = clamp_pos(sum_y, max_y_q);
						btn_d     = head_q[2:0] & BTN_BITS[2:0];
						res_valid = 1'b1;
					end
				end
			endcase
		end

		if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_X:   max_x_d = cfg.data;
				REG_MAX_Y:   max_y_d = cfg.data;
				REG_START_X: cur_x_d = cfg.data;
				REG_START_Y: cur_y_d = cfg.data;
				default:     ;
			endcase
		end
	end

	assign res.pos_x       = cur_x_d;
	assign res.pos_y       = cur_y_d;
	assign res.button_bits = btn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= BP_HEAD;
			head_q     <= '0;
			dx_q       <= '0;
			cur_x_q    <= CURS_X_RST;
			cur_y_q    <= CURS_Y_RST;
			btn_q      <= '0;
			max_x_q    <= MAX_X_RST;
			max_y_q    <= MAX_Y_RST;
		end else begin
			byte_pos_q <= byte_pos_d;
			head_q     <= head_d;
			dx_q       <= dx_d;
			cur_x_q    <= cur_x_d;
			cur_y_q    <= cur_y_d;
			btn_q      <= btn_d;
			max_x_q    <= max_x_d;
			max_y_q    <= max_y_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/pmpt_out_stage.sv @@
`default_nettype none
module pmpt_out_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pmpt_pkg::flow_t     flow,
	input  wire logic                res_valid,
	input  wire pmpt_pkg::out_item_t res,
	output logic                     advance,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output pmpt_pkg::out_item_t      result
);
	import pmpt_pkg::*;

	logic      out_valid_q;
	out_item_t out_data_q;

	// Free when empty or when the held request leaves this cycle.
	assign advance      = ~out_valid_q | ~result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flow.fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.fire && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ps2_mouse_packet_tracker_top.sv @@
`default_nettype none
// PS/2 mouse packet tracker: each request carries a controller status byte and
// its data byte; aux bytes are gathered into three-byte packets, and each
// complete packet without overflow moves the clamped cursor and yields one
// result with position and buttons. One request is taken every cycle unless
// item_stall is high; the request that completes a packet is held in the input
// register, and its result then in the result register. A stalled result holds
// the input register, so item_stall follows result_stall in the same cycle.
// Register writes are always taken (cfg_ready is high) and must only come
// while no request is in flight.
module ps2_mouse_packet_tracker_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire pmpt_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output pmpt_pkg::out_item_t      result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire pmpt_pkg::cfg_idx_t  cfg_index,
	input  wire logic [pmpt_pkg::POS_BITS-1:0] cfg_data
);
	import pmpt_pkg::*;

	flow_t     flow;
	in_item_t  item_s1;
	cfg_req_t  cfg;
	logic      advance;
	logic      res_valid;
	out_item_t res;

	assign cfg_ready = 1'b1;
	assign cfg.valid = cfg_valid & cfg_ready;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	pmpt_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (advance),
		.flow       (flow),
		.item_s1    (item_s1)
	);

	pmpt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow),
		.item_s1   (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	pmpt_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.flow         (flow),
		.res_valid    (res_valid),
		.res          (res),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

@@ hw/rtl/pmpt_checker.sv @@
`default_nettype none
`include "ps2_mouse_packet_tracker_top_assert.svh"
module pmpt_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_stall,
	input wire pmpt_pkg::in_item_t  item,
	input wire logic                result_valid,
	input wire logic                result_stall,
	input wire pmpt_pkg::out_item_t result,
	input wire logic                cfg_valid,
	input wire logic                cfg_ready,
	input wire pmpt_pkg::cfg_idx_t  cfg_index,
	input wire logic [pmpt_pkg::POS_BITS-1:0] cfg_data
);
	import pmpt_pkg::*;

	logic [POS_BITS-1:0] max_x_q;
	logic [POS_BITS-1:0] max_y_q;

	// Mirror the limit registers from the write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RST;
			max_y_q <= MAX_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MAX_X) begin
				max_x_q <= cfg_data;
			end
			if (cfg_index == REG_MAX_Y) begin
				max_y_q <= cfg_data;
			end
		end
	end

	`PMPT_ASSERT_NEXT(a_item_hold, clk, arst_n, item_valid && item_stall,
		item_valid && $stable(item))
	`PMPT_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result))
	`PMPT_ASSERT_SAME(a_stall_cause, clk, arst_n, item_stall,
		result_valid && result_stall)
	`PMPT_ASSERT_SAME(a_x_in_range, clk, arst_n, result_valid, result.pos_x <= max_x_q)
	`PMPT_ASSERT_SAME(a_y_in_range, clk, arst_n, result_valid, result.pos_y <= max_y_q)

endmodule

bind ps2_mouse_packet_tracker_top pmpt_checker u_pmpt_checker (.*);
`default_nettype wire

@@ tb/ps2_mouse_packet_tracker_top_tb.sv @@
module ps2_mouse_packet_tracker_top_tb;
	import pmpt_pkg::*;

	localparam logic [7:0] AUX_FULL = ST_AUX | ST_OUT_FULL;
	localparam int MAX_GAP = 18;
	localparam int DRAIN_CYCLES = 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int PHASES = 8;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

	typedef struct {
		in_item_t  req;
		row_kind_t kind;
		out_item_t rpt;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	in_item_t            item;
	logic                result_valid;
	logic                result_stall;
	out_item_t           result;
	logic                cfg_valid;
	logic                cfg_ready;
	cfg_idx_t            cfg_index;
	logic [POS_BITS-1:0] cfg_data;

	// cursor tracker state
	logic [1:0]          pkt_pos;
	logic [7:0]          pkt_head;
	logic [7:0]          pkt_dx;
	logic [POS_BITS-1:0] cur_x;
	logic [POS_BITS-1:0] cur_y;
	logic [POS_BITS-1:0] lim_x;
	logic [POS_BITS-1:0] lim_y;
	logic [2:0]          cur_buttons;

	out_item_t cursor_reports_q[$];
	stim_row_t directed_rows[$];
	int        mismatches;
	int        idle_cycles;
	int        stall_left;
	int        full_items;
	bit        quiet;

	ps2_mouse_packet_tracker_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [POS_BITS-1:0] clamp_pos(int v, logic [POS_BITS-1:0] hi);
		if (v < 0)
			return '0;
		if (v > int'(hi))
			return hi;
		return v[POS_BITS-1:0];
	endfunction

	task automatic apply_config(input cfg_idx_t idx, input logic [POS_BITS-1:0] val);
		case (idx)
			REG_MAX_X:   lim_x = val;
			REG_MAX_Y:   lim_y = val;
			REG_START_X: cur_x = val;
			REG_START_Y: cur_y = val;
			default: ;
		endcase
	endtask

	task automatic track_byte(input in_item_t req, output bit emits, output out_item_t rpt);
		int nx;
		int ny;
		emits = 1'b0;
		rpt = '0;
		if ((req.status_byte & ST_OUT_FULL) == 8'h00)
			return;
		if ((req.status_byte & ST_AUX) == 8'h00)
			return;
		if (pkt_pos == 2'd0) begin
			// wait for a head byte with the sync bit
			if ((req.data_byte & SYNC_BIT) == 8'h00)
				return;
			pkt_head = req.data_byte;
			pkt_pos = 2'd1;
			return;
		end
		if (pkt_pos == 2'd1) begin
			pkt_dx = req.data_byte;
			pkt_pos = 2'd2;
			return;
		end
		pkt_pos = 2'd0;
		if ((pkt_head & OVF_BITS) != 8'h00)
			return;
		nx = int'(cur_x) + int'($signed(pkt_dx));
		ny = int'(cur_y) - int'($signed(req.data_byte));
		cur_x = clamp_pos(nx, lim_x);
		cur_y = clamp_pos(ny, lim_y);
		cur_buttons = 3'(pkt_head & BTN_BITS);
		rpt.pos_x = cur_x;
		rpt.pos_y = cur_y;
		rpt.button_bits = cur_buttons;
		emits = 1'b1;
	endtask

	task automatic add_row(input logic [7:0] st, input logic [7:0] d, input row_kind_t k,
			input int x = 0, input int y = 0, input int b = 0);
		stim_row_t row;
		row.req.status_byte = st;
		row.req.data_byte = d;
		row.kind = k;
		row.rpt.pos_x = POS_BITS'(x);
		row.rpt.pos_y = POS_BITS'(y);
		row.rpt.button_bits = 3'(b);
		directed_rows.push_back(row);
	endtask

	task automatic send_request(input in_item_t req, input row_kind_t kind, input out_item_t typed);
		int        gap;
		bit        emits;
		out_item_t rpt;
		if (quiet || $urandom_range(0, 3) == 0)
			gap = 0;
		else
			gap = $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
		if ((req.status_byte & ST_OUT_FULL) != 8'h00)
			full_items++;
		track_byte(req, emits, rpt);
		if (kind == ROW_RESULT)
			cursor_reports_q.push_back(typed);
		else if (kind == ROW_PREDICT && emits)
			cursor_reports_q.push_back(rpt);
	endtask

	task automatic send_byte(input logic [7:0] st, input logic [7:0] d);
		in_item_t req;
		req.status_byte = st;
		req.data_byte = d;
		send_request(req, ROW_PREDICT, '0);
	endtask

	task automatic send_noise();
		send_byte(8'($urandom), 8'($urandom));
	endtask

	task automatic send_random(input int target);
		logic [7:0] pkt[3];
		while (full_items < target) begin
			if ($urandom_range(0, 99) < 80) begin
				pkt[0] = 8'($urandom) | SYNC_BIT;
				if ($urandom_range(0, 99) < 85)
					pkt[0] = pkt[0] & ~OVF_BITS;
				pkt[1] = 8'($urandom);
				pkt[2] = 8'($urandom);
				foreach (pkt[i]) begin
					if ($urandom_range(0, 99) < 8)
						send_noise();
					send_byte(8'($urandom) | AUX_FULL, pkt[i]);
				end
			end else begin
				send_noise();
			end
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [POS_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_config(idx, val);
	endtask

	// hold until every report is in and the pipeline has emptied
	task automatic settle();
		while (cursor_reports_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_report(input out_item_t got);
		out_item_t want;
		if (cursor_reports_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("unexpected report: x=%0d y=%0d buttons=%03b",
					got.pos_x, got.pos_y, got.button_bits);
			return;
		end
		want = cursor_reports_q.pop_front();
		if (want.pos_x !== got.pos_x || want.pos_y !== got.pos_y
				|| want.button_bits !== got.button_bits) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("report mismatch: expected x=%0d y=%0d buttons=%03b, got x=%0d y=%0d buttons=%03b",
					want.pos_x, want.pos_y, want.button_bits,
					got.pos_x, got.pos_y, got.button_bits);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				check_report(result);
				stall_left = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			result_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [POS_BITS-1:0] setting[4];
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_X;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		stall_left = 0;
		full_items = 0;
		quiet = 1'b0;
		pkt_pos = 2'd0;
		pkt_head = 8'h00;
		pkt_dx = 8'h00;
		cur_x = CURS_X_RST;
		cur_y = CURS_Y_RST;
		lim_x = MAX_X_RST;
		lim_y = MAX_Y_RST;
		cur_buttons = 3'b000;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 80x25 area, cursor at 40,12
		add_row(8'h00, 8'hFF, ROW_NONE);                // output not full
		add_row(ST_OUT_FULL, 8'h08, ROW_NONE);          // keyboard byte
		add_row(AUX_FULL, 8'h00, ROW_NONE);             // head without sync
		add_row(AUX_FULL, 8'h09, ROW_NONE);
		add_row(AUX_FULL, 8'h7F, ROW_NONE);
		add_row(AUX_FULL, 8'h80, ROW_RESULT, 79, 24, 1); // clamp at both maxima
		add_row(8'hFF, 8'h0F, ROW_NONE);
		add_row(8'hFF, 8'h80, ROW_NONE);
		add_row(8'hFF, 8'h7F, ROW_RESULT, 0, 0, 7);     // clamp at zero
		add_row(AUX_FULL, 8'hC8, ROW_NONE);             // both overflow bits
		add_row(AUX_FULL, 8'h01, ROW_NONE);
		add_row(AUX_FULL, 8'h01, ROW_NONE);
		add_row(AUX_FULL, 8'h4A, ROW_NONE);             // x overflow
		add_row(AUX_FULL, 8'h10, ROW_NONE);
		add_row(AUX_FULL, 8'h10, ROW_NONE);
		add_row(AUX_FULL, 8'h8C, ROW_NONE);             // y overflow
		add_row(AUX_FULL, 8'h20, ROW_NONE);
		add_row(AUX_FULL, 8'h20, ROW_NONE);
		add_row(AUX_FULL, 8'h08, ROW_NONE);
		add_row(AUX_FULL, 8'h05, ROW_NONE);
		add_row(8'hDF, 8'h00, ROW_NONE);                // keyboard byte mid-packet
		add_row(ST_AUX, 8'h00, ROW_NONE);               // aux flag but not full
		add_row(AUX_FULL, 8'hFD, ROW_RESULT, 5, 3, 0);
		add_row(AUX_FULL, 8'h0E, ROW_PREDICT);
		add_row(AUX_FULL, 8'h00, ROW_PREDICT);
		add_row(AUX_FULL, 8'h00, ROW_PREDICT);
		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].kind, directed_rows[i].rpt);
		item_valid <= 1'b0;
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: setting = '{12'd4095, 12'd4095, 12'd2048, 12'd2048};
				1: setting = '{12'd0, 12'd0, 12'd0, 12'd0};
				2: setting = '{12'd100, 12'd50, 12'd4095, 12'd4095}; // start beyond max
				3: setting = '{12'd639, 12'd479, 12'd320, 12'd240};
				4: setting = '{12'd4095, 12'd4095, 12'd0, 12'd4095};
				default: begin
					setting[0] = 12'($urandom_range(0, 4095));
					setting[1] = 12'($urandom_range(0, 4095));
					setting[2] = 12'($urandom_range(0, 4095));
					setting[3] = 12'($urandom_range(0, 4095));
				end
			endcase
			write_reg(REG_MAX_X, setting[0]);
			write_reg(REG_MAX_Y, setting[1]);
			write_reg(REG_START_X, setting[2]);
			write_reg(REG_START_Y, setting[3]);
			cfg_valid <= 1'b0;
			quiet = (phase % 3 == 2);
			send_random(full_items + RANDOM_ITEMS / PHASES);
			item_valid <= 1'b0;
			quiet = 1'b0;
			settle();
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
